// ===== src/bci_pkg.sv =====
package bci_pkg;

  localparam int TAP_W   = 8;
  localparam int FRAC_W  = 9;
  localparam int PIX_W   = 8;
  localparam int F2_W    = 17;
  localparam int F3_W    = 25;
  localparam int COEF_W  = 28;
  localparam int OPB_W   = 20;
  localparam int PROD_W  = COEF_W + OPB_W;
  localparam int ROW_W   = 37;
  localparam int ROW_LO_W = 18;
  localparam int ACC_W   = 64;
  localparam int SUM_SHIFT = 50;

  localparam logic [FRAC_W-1:0] ONE_Q8  = 9'd256;
  localparam logic [PIX_W-1:0]  PIX_MAX = 8'd255;

  // Keys a = -1/2 weights, scaled by 2^25; sel picks the neighbor position.
  function automatic logic signed [COEF_W-1:0] coef(input logic [1:0] sel,
                                                     input logic [FRAC_W-1:0] f,
                                                     input logic [F2_W-1:0] f2,
                                                     input logic [F3_W-1:0] f3);
    logic signed [29:0] sf;
    logic signed [29:0] sf2;
    logic signed [29:0] sf3;
    logic signed [29:0] k;
    sf  = signed'({21'd0, f});
    sf2 = signed'({13'd0, f2});
    sf3 = signed'({5'd0, f3});
    unique case (sel)
      2'd0:    k = -sf3 + (sf2 <<< 9) - (sf <<< 16);
      2'd1:    k = sf3 + (sf3 <<< 1) - (sf2 <<< 10) - (sf2 <<< 8) + 30'sd33554432;
      2'd2:    k = -sf3 - (sf3 <<< 1) + (sf2 <<< 10) + (sf <<< 16);
      default: k = sf3 - (sf2 <<< 8);
    endcase
    return signed'(k[COEF_W-1:0]);
  endfunction

endpackage

// ===== src/bci_if.sv =====
interface bci_in_if;
  logic                         valid;
  logic                         ready;
  logic [bci_pkg::TAP_W-1:0]    tap_a;
  logic [bci_pkg::TAP_W-1:0]    tap_b;
  logic [bci_pkg::TAP_W-1:0]    tap_c;
  logic [bci_pkg::TAP_W-1:0]    tap_d;
  logic [bci_pkg::FRAC_W-1:0]   frac_x;
  logic [bci_pkg::FRAC_W-1:0]   frac_y;

  modport source (output valid, tap_a, tap_b, tap_c, tap_d, frac_x, frac_y, input ready);
  modport sink   (input valid, tap_a, tap_b, tap_c, tap_d, frac_x, frac_y, output ready);
endinterface

interface bci_out_if;
  logic                         valid;
  logic                         ready;
  logic [bci_pkg::PIX_W-1:0]    pixel_value;

  modport source (output valid, pixel_value, input ready);
  modport sink   (input valid, pixel_value, output ready);
endinterface

// ===== src/bci_mul.sv =====
module bci_mul (
  input  logic                               clk,
  input  logic signed [bci_pkg::COEF_W-1:0]  op_a,
  input  logic signed [bci_pkg::OPB_W-1:0]   op_b,
  output logic signed [bci_pkg::PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= bci_pkg::PROD_W'(op_a) * bci_pkg::PROD_W'(op_b);
  end

endmodule

// ===== src/bicubic_interpolate_channel_top.sv =====
// Keys bicubic (a = -1/2) interpolation of one 8-bit channel. Feed the four source
// rows of a pixel top to bottom, one row per input transfer, each with the same
// frac_x and frac_y (unsigned Q8, values above 256 saturate to 256). After the fourth
// row one pixel_value transfer follows: floor of the exact weighted sum, clamped to
// 0..255. Every row passes through a single 28x20 multiplier under a step sequencer
// (fraction powers, four tap products, then the row times its y weight in two
// halves), so a row is accepted only once the last one is through; the final step
// stalls while a finished pixel waits in the output register and the next one is due.
module bicubic_interpolate_channel_top (
  input  logic        clk,
  input  logic        rst_n,
  bci_in_if.sink      in_chan,
  bci_out_if.source   out_chan
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQX  = 4'd1;
  localparam logic [3:0] ST_SQY  = 4'd2;
  localparam logic [3:0] ST_CUX  = 4'd3;
  localparam logic [3:0] ST_CUY  = 4'd4;
  localparam logic [3:0] ST_TP0  = 4'd5;
  localparam logic [3:0] ST_TP1  = 4'd6;
  localparam logic [3:0] ST_TP2  = 4'd7;
  localparam logic [3:0] ST_TP3  = 4'd8;
  localparam logic [3:0] ST_ROWE = 4'd9;
  localparam logic [3:0] ST_LO   = 4'd10;
  localparam logic [3:0] ST_HI   = 4'd11;
  localparam logic [3:0] ST_ACCH = 4'd12;
  localparam logic [3:0] ST_FIN  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [1:0] row_idx_r;

  logic [bci_pkg::TAP_W-1:0]  tap_a_r, tap_b_r, tap_c_r, tap_d_r;
  logic [bci_pkg::FRAC_W-1:0] fx_r, fy_r;
  logic [bci_pkg::F2_W-1:0]   f2x_r, f2y_r;
  logic [bci_pkg::F3_W-1:0]   f3x_r, f3y_r;
  logic signed [bci_pkg::ROW_W-1:0] row_r;
  logic signed [bci_pkg::ACC_W-1:0] acc_r;

  logic                         out_valid_r;
  logic [bci_pkg::PIX_W-1:0]    out_pix_r;

  logic signed [bci_pkg::COEF_W-1:0] op_a;
  logic signed [bci_pkg::OPB_W-1:0]  op_b;
  logic signed [bci_pkg::PROD_W-1:0] prod_r;
  logic signed [bci_pkg::ACC_W-1:0]  prod_ext;
  logic signed [bci_pkg::COEF_W-1:0] ky;
  logic [1:0]                        tap_sel;
  logic [bci_pkg::TAP_W-1:0]         tap_cur;
  logic                              in_xfer;
  logic                              emit;
  logic [bci_pkg::PIX_W-1:0]         pix_val;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_value = out_pix_r;

  assign emit = (state_r == ST_FIN) && (row_idx_r == 2'd3) &&
                (!out_valid_r || out_chan.ready);

  assign prod_ext = {{(bci_pkg::ACC_W - bci_pkg::PROD_W){prod_r[bci_pkg::PROD_W-1]}}, prod_r};
  assign ky = bci_pkg::coef(row_idx_r, fy_r, f2y_r, f3y_r);

  always_comb begin
    unique case (state_r)
      ST_TP1:  tap_sel = 2'd1;
      ST_TP2:  tap_sel = 2'd2;
      ST_TP3:  tap_sel = 2'd3;
      default: tap_sel = 2'd0;
    endcase
    unique case (tap_sel)
      2'd0:    tap_cur = tap_a_r;
      2'd1:    tap_cur = tap_b_r;
      2'd2:    tap_cur = tap_c_r;
      default: tap_cur = tap_d_r;
    endcase
  end

  // Operand select for the shared multiplier
  always_comb begin
    unique case (state_r)
      ST_SQX: begin
        op_a = signed'({19'd0, fx_r});
        op_b = signed'({11'd0, fx_r});
      end
      ST_SQY: begin
        op_a = signed'({19'd0, fy_r});
        op_b = signed'({11'd0, fy_r});
      end
      ST_CUX: begin
        op_a = signed'({11'd0, f2x_r});
        op_b = signed'({11'd0, fx_r});
      end
      ST_CUY: begin
        op_a = signed'({11'd0, f2y_r});
        op_b = signed'({11'd0, fy_r});
      end
      ST_TP0, ST_TP1, ST_TP2, ST_TP3: begin
        op_a = bci_pkg::coef(tap_sel, fx_r, f2x_r, f3x_r);
        op_b = signed'({12'd0, tap_cur});
      end
      ST_LO: begin
        op_a = ky;
        op_b = signed'({2'd0, row_r[bci_pkg::ROW_LO_W-1:0]});
      end
      ST_HI: begin
        op_a = ky;
        op_b = {row_r[bci_pkg::ROW_W-1], row_r[bci_pkg::ROW_W-1:bci_pkg::ROW_LO_W]};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  bci_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = in_xfer ? ST_SQX : ST_IDLE;
      ST_FIN:  state_nxt = ((row_idx_r != 2'd3) || emit) ? ST_IDLE : ST_FIN;
      default: state_nxt = state_r + 4'd1;
    endcase
  end

  // Floor and clamp of the Q50 sum
  always_comb begin
    priority if (acc_r[bci_pkg::ACC_W-1]) begin
      pix_val = '0;
    end else if (|acc_r[bci_pkg::ACC_W-2:bci_pkg::SUM_SHIFT+bci_pkg::PIX_W]) begin
      pix_val = bci_pkg::PIX_MAX;
    end else begin
      pix_val = acc_r[bci_pkg::SUM_SHIFT+bci_pkg::PIX_W-1:bci_pkg::SUM_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_idx_r   <= 2'd0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_HI:   acc_r <= acc_r + prod_ext;
        ST_ACCH: acc_r <= acc_r + (prod_ext <<< bci_pkg::ROW_LO_W);
        ST_FIN: begin
          if (emit) begin
            acc_r     <= '0;
            row_idx_r <= 2'd0;
          end else if (row_idx_r != 2'd3) begin
            row_idx_r <= row_idx_r + 2'd1;
          end
        end
        default: ;
      endcase
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tap_a_r <= in_chan.tap_a;
      tap_b_r <= in_chan.tap_b;
      tap_c_r <= in_chan.tap_c;
      tap_d_r <= in_chan.tap_d;
      fx_r    <= (in_chan.frac_x > bci_pkg::ONE_Q8) ? bci_pkg::ONE_Q8 : in_chan.frac_x;
      fy_r    <= (in_chan.frac_y > bci_pkg::ONE_Q8) ? bci_pkg::ONE_Q8 : in_chan.frac_y;
    end
    unique case (state_r)
      ST_SQY:  f2x_r <= prod_r[bci_pkg::F2_W-1:0];
      ST_CUX:  f2y_r <= prod_r[bci_pkg::F2_W-1:0];
      ST_CUY:  f3x_r <= prod_r[bci_pkg::F3_W-1:0];
      ST_TP0: begin
        f3y_r <= prod_r[bci_pkg::F3_W-1:0];
        row_r <= '0;
      end
      ST_TP1, ST_TP2, ST_TP3, ST_ROWE: row_r <= row_r + prod_r[bci_pkg::ROW_W-1:0];
      default: ;
    endcase
    if (emit) begin
      out_pix_r <= pix_val;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_SQX))
    else $error("accepted row did not start the sequence");

  a_emit_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |->
      ($past(state_r) == ST_FIN) && ($past(row_idx_r) == 2'd3))
    else $error("pixel issued before the fourth row");

  a_row_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && ($past(state_r) != ST_FIN) |-> $stable(row_idx_r))
    else $error("row index moved outside the final step");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int PIXELS_RANDOM = 225;
  localparam int IDLE_LIMIT    = 1000;
  localparam int TAIL_CYCLES   = 64;

  typedef struct packed {
    logic [bci_pkg::TAP_W-1:0]  tap_a;
    logic [bci_pkg::TAP_W-1:0]  tap_b;
    logic [bci_pkg::TAP_W-1:0]  tap_c;
    logic [bci_pkg::TAP_W-1:0]  tap_d;
    logic [bci_pkg::FRAC_W-1:0] frac_x;
    logic [bci_pkg::FRAC_W-1:0] frac_y;
  } row_t;

  // Folds accepted rows into an exact weighted sum and queues the pixel each fourth row makes.
  class pixel_tracker;
    int unsigned               row_idx;
    longint                    weighted_sum;
    logic [bci_pkg::PIX_W-1:0] pending_pixels[$];
    int                        fail_count;

    function new();
      row_idx = 0;
      weighted_sum = 0;
      fail_count = 0;
    endfunction

    task report(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      fail_count++;
    endtask

    // Keys weights scaled by 2^25, fraction clamped to one.
    function void keys_weights(input logic [bci_pkg::FRAC_W-1:0] raw, output longint w[4]);
      longint f;
      longint f2;
      longint f3;
      f  = (raw > bci_pkg::ONE_Q8) ? longint'(bci_pkg::ONE_Q8) : longint'(raw);
      f2 = f * f;
      f3 = f2 * f;
      w[0] = -f3 + 512 * f2 - 65536 * f;
      w[1] = 3 * f3 - 1280 * f2 + (longint'(1) << 25);
      w[2] = -3 * f3 + 1024 * f2 + 65536 * f;
      w[3] = f3 - 256 * f2;
    endfunction

    function void fold_row(input row_t r);
      longint kx[4];
      longint ky[4];
      longint row_sum;
      longint level;
      keys_weights(r.frac_x, kx);
      keys_weights(r.frac_y, ky);
      row_sum = longint'(r.tap_a) * kx[0] + longint'(r.tap_b) * kx[1]
              + longint'(r.tap_c) * kx[2] + longint'(r.tap_d) * kx[3];
      weighted_sum += row_sum * ky[row_idx];
      if (row_idx != 3) begin
        row_idx++;
        return;
      end
      if (weighted_sum < 0) begin
        pending_pixels.push_back('0);
      end else begin
        level = weighted_sum >>> bci_pkg::SUM_SHIFT;
        pending_pixels.push_back((level > 255) ? bci_pkg::PIX_MAX
                                               : level[bci_pkg::PIX_W-1:0]);
      end
      row_idx = 0;
      weighted_sum = 0;
    endfunction

    task check_pixel(input logic [bci_pkg::PIX_W-1:0] got);
      logic [bci_pkg::PIX_W-1:0] want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("pixel_value %0d with no pixel pending", got));
        return;
      end
      want = pending_pixels.pop_front();
      if (got !== want)
        report($sformatf("pixel_value got %0d want %0d", got, want));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   idle_cycles = 0;

  bci_in_if  in_chan();
  bci_out_if out_chan();

  pixel_tracker tracker;

  bicubic_interpolate_channel_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sample transfers on pre-edge values; the watchdog counts edges with no transfer.
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      tracker.fold_row({in_chan.tap_a, in_chan.tap_b, in_chan.tap_c, in_chan.tap_d,
                        in_chan.frac_x, in_chan.frac_y});
    if (rst_n && out_chan.valid && out_chan.ready)
      tracker.check_pixel(out_chan.pixel_value);
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_row(input row_t r, input bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.tap_a  <= r.tap_a;
    in_chan.tap_b  <= r.tap_b;
    in_chan.tap_c  <= r.tap_c;
    in_chan.tap_d  <= r.tap_d;
    in_chan.frac_x <= r.frac_x;
    in_chan.frac_y <= r.frac_y;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic send_uniform(input logic [bci_pkg::TAP_W-1:0] a,
                              input logic [bci_pkg::TAP_W-1:0] b,
                              input logic [bci_pkg::TAP_W-1:0] c,
                              input logic [bci_pkg::TAP_W-1:0] d,
                              input logic [bci_pkg::FRAC_W-1:0] fx,
                              input logic [bci_pkg::FRAC_W-1:0] fy);
    repeat (4) send_row({a, b, c, d, fx, fy}, 1'b0);
  endtask

  function automatic logic [bci_pkg::FRAC_W-1:0] draw_frac();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return bci_pkg::ONE_Q8;
      2:       return bci_pkg::FRAC_W'($urandom_range(257, 511));
      3:       return bci_pkg::FRAC_W'($urandom_range(0, 511));
      default: return bci_pkg::FRAC_W'($urandom_range(0, 256));
    endcase
  endfunction

  // Tap styles: rails only, overshoot (dark-bright-bright-dark), undershoot, plain random.
  task automatic send_random_pixel();
    row_t r;
    bit   calm;
    bit   vary;
    int   style;
    calm  = ($urandom_range(0, 4) == 0);
    vary  = ($urandom_range(0, 9) == 0);
    style = $urandom_range(0, 5);
    r.frac_x = draw_frac();
    r.frac_y = draw_frac();
    for (int i = 0; i < 4; i++) begin
      if (vary) begin
        r.frac_x = draw_frac();
        r.frac_y = draw_frac();
      end
      case (style)
        0: begin
          r.tap_a = $urandom_range(0, 1) ? bci_pkg::PIX_MAX : '0;
          r.tap_b = $urandom_range(0, 1) ? bci_pkg::PIX_MAX : '0;
          r.tap_c = $urandom_range(0, 1) ? bci_pkg::PIX_MAX : '0;
          r.tap_d = $urandom_range(0, 1) ? bci_pkg::PIX_MAX : '0;
        end
        1: begin
          r.tap_a = bci_pkg::TAP_W'($urandom_range(0, 40));
          r.tap_b = bci_pkg::TAP_W'($urandom_range(215, 255));
          r.tap_c = bci_pkg::TAP_W'($urandom_range(215, 255));
          r.tap_d = bci_pkg::TAP_W'($urandom_range(0, 40));
        end
        2: begin
          r.tap_a = bci_pkg::TAP_W'($urandom_range(215, 255));
          r.tap_b = bci_pkg::TAP_W'($urandom_range(0, 40));
          r.tap_c = bci_pkg::TAP_W'($urandom_range(0, 40));
          r.tap_d = bci_pkg::TAP_W'($urandom_range(215, 255));
        end
        default: begin
          r.tap_a = bci_pkg::TAP_W'($urandom_range(0, 255));
          r.tap_b = bci_pkg::TAP_W'($urandom_range(0, 255));
          r.tap_c = bci_pkg::TAP_W'($urandom_range(0, 255));
          r.tap_d = bci_pkg::TAP_W'($urandom_range(0, 255));
        end
      endcase
      send_row(r, calm);
    end
  endtask

  // Result side: stall a random number of cycles before each transfer.
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  initial begin
    row_t r;
    tracker = new();
    rst_n = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.tap_a  = '0;
    in_chan.tap_b  = '0;
    in_chan.tap_c  = '0;
    in_chan.tap_d  = '0;
    in_chan.frac_x = '0;
    in_chan.frac_y = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: flat black, flat white at full fractions, undershoot below zero,
    // overshoot above full scale, fractions above one, near-zero and near-one fractions.
    send_uniform(8'd0, 8'd0, 8'd0, 8'd0, 9'd0, 9'd0);
    send_uniform(8'd255, 8'd255, 8'd255, 8'd255, bci_pkg::ONE_Q8, bci_pkg::ONE_Q8);
    send_uniform(8'd255, 8'd0, 8'd0, 8'd255, 9'd128, 9'd128);
    send_uniform(8'd0, 8'd255, 8'd255, 8'd0, 9'd128, 9'd128);
    for (int i = 0; i < 4; i++) begin
      r = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 9'd511, 9'd257};
      send_row(r, 1'b0);
    end
    for (int i = 0; i < 4; i++) begin
      if (i % 2 == 0)
        r = {8'hAA, 8'h55, 8'hAA, 8'h55, 9'd1, 9'd255};
      else
        r = {8'h55, 8'hAA, 8'h55, 8'hAA, 9'd1, 9'd255};
      send_row(r, 1'b1);
    end

    for (int n = 0; n < PIXELS_RANDOM; n++)
      send_random_pixel();
    in_chan.valid <= 1'b0;

    // Drain, then give a stray pixel time to show up.
    while (tracker.pending_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.pending_pixels.size() != 0)
      tracker.report($sformatf("%0d pixels never arrived", tracker.pending_pixels.size()));

    if (tracker.fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
